[rtl/suld_pkg.sv]
// shared types and constants for the sextet unpacker with lfsr descrambler
package suld_pkg;

  localparam int unsigned LFSR_W   = 32;
  localparam int unsigned SYM_W    = 6;
  localparam int unsigned OFS_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LFSR_W-1:0] SEED_RESET = 32'h1102_8891;
  localparam logic [LFSR_W-1:0] MASK_RESET = 32'hb4bc_d35c;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 1'b1;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_SYMBOL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYNC,
    ST_DESC
  } state_t;

  typedef enum logic [1:0] {
    BYTE_0,
    BYTE_1,
    BYTE_2
  } byte_sel_t;

  // control from the sequencer to the lfsr unit
  typedef struct packed {
    logic load;
    logic step;
  } lfsr_ctl_t;

endpackage

[rtl/suld_lfsr.sv]
// galois lfsr register with its shared one-step update unit
module suld_lfsr
  import suld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lfsr_ctl_t         ctl,
  input  logic [LFSR_W-1:0] seed,
  input  logic [LFSR_W-1:0] mask,
  output logic [LFSR_W-1:0] lfsr
);

  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_nxt;
  logic [LFSR_W-1:0] stepped;

  assign stepped = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? mask : '0);

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (ctl.load) begin
      lfsr_nxt = seed;
    end else if (ctl.step) begin
      lfsr_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_RESET;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

  assign lfsr = lfsr_r;

endmodule

[rtl/sextet_unpack_lfsr_descrambler.sv]
// top level: sextet packing, sequencer and output register around the lfsr unit
// flow: a symbol inside a group is only buffered, no result; a closing symbol is accepted, then
//   its three bytes are descrambled, one lfsr step per byte, the last waiting for a free output
//   slot, result valid the cycle after; 1 symbol per cycle inside a group, none while busy;
//   a restart walks (char_offset*3)>>2 lfsr steps on the single shared step unit, taking no input
// reset: sync active-low rst_n clears sequencer, count and output valid; cfg and lfsr to defaults
module sextet_unpack_lfsr_descrambler
  import suld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LFSR_W-1:0]    cfg_wdata,
  // input transactions
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [OFS_W-1:0]     in_char_offset,
  input  logic [SYM_W-1:0]     in_sextet,
  // result transactions
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_duration,
  output logic [7:0]           out_brightness,
  output logic [3:0]           out_octave,
  output logic [3:0]           out_note,
  output logic                 out_end_marker
);

  // configuration registers
  logic [LFSR_W-1:0] seed_r;
  logic [LFSR_W-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED: seed_r <= cfg_wdata;
        CFG_MASK: mask_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // sequencer and datapath state
  state_t             state_r, state_nxt;
  byte_sel_t          byte_r, byte_nxt;
  logic [1:0]         count_r, count_nxt;
  logic [3*SYM_W-1:0] buf_r, buf_nxt;        // up to three held sextets
  logic [4*SYM_W-1:0] word_r, word_nxt;      // full group of four, three bytes
  logic [OFS_W-1:0]   sync_r, sync_nxt;      // lfsr steps still to take on restart
  logic [7:0]         d0_r, d0_nxt;
  logic [7:0]         d1_r, d1_nxt;

  // output register
  logic               ovalid_r, ovalid_nxt;
  logic [7:0]         odur_r, obri_r;
  logic [3:0]         ooct_r, onote_r;
  logic               oend_r;
  logic               oload;

  lfsr_ctl_t          lfsr_ctl;
  logic [LFSR_W-1:0]  lfsr;

  logic               in_acc;
  logic               slot_free;
  logic [OFS_W+1:0]   ofs_x3;
  logic [OFS_W-1:0]   steps;
  logic [7:0]         cur_byte;
  logic [7:0]         plain;

  suld_lfsr u_lfsr (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lfsr_ctl),
    .seed  (seed_r),
    .mask  (mask_r),
    .lfsr  (lfsr)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !ovalid_r || out_ready;

  // (offset*3)>>2 as offset + 2*offset, then drop two bits
  assign ofs_x3 = {2'b00, in_char_offset} + {1'b0, in_char_offset, 1'b0};
  assign steps  = ofs_x3[OFS_W+1:2];

  // pick the byte of the group being descrambled, first byte most significant
  always_comb begin
    case (byte_r)
      BYTE_0:  cur_byte = word_r[23:16];
      BYTE_1:  cur_byte = word_r[15:8];
      default: cur_byte = word_r[7:0];
    endcase
  end

  assign plain = cur_byte ^ lfsr[7:0];

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    count_nxt     = count_r;
    buf_nxt       = buf_r;
    word_nxt      = word_r;
    sync_nxt      = sync_r;
    d0_nxt        = d0_r;
    d1_nxt        = d1_r;
    lfsr_ctl.load = 1'b0;
    lfsr_ctl.step = 1'b0;
    oload         = 1'b0;
    ovalid_nxt    = ovalid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_RESTART) begin
            // reload seed, drop any partial group, then walk the lfsr forward
            lfsr_ctl.load = 1'b1;
            count_nxt     = '0;
            buf_nxt       = '0;
            sync_nxt      = steps;
            if (steps != '0) begin
              state_nxt = ST_SYNC;
            end
          end else if (count_r != 2'd3) begin
            buf_nxt   = {buf_r[2*SYM_W-1:0], in_sextet};
            count_nxt = count_r + 2'd1;
          end else begin
            // group complete: latch it and descramble one byte per cycle, the last once the output is free
            word_nxt  = {buf_r, in_sextet};
            buf_nxt   = '0;
            count_nxt = '0;
            byte_nxt  = BYTE_0;
            state_nxt = ST_DESC;
          end
        end
      end
      ST_SYNC: begin
        lfsr_ctl.step = 1'b1;
        sync_nxt      = sync_r - 16'd1;
        if (sync_r == 16'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DESC: begin
        unique case (byte_r)
          BYTE_0: begin
            d0_nxt        = plain;
            lfsr_ctl.step = 1'b1;
            byte_nxt      = BYTE_1;
          end
          BYTE_1: begin
            d1_nxt        = plain;
            lfsr_ctl.step = 1'b1;
            byte_nxt      = BYTE_2;
          end
          default: begin
            // last byte waits for the output register to free up
            if (slot_free) begin
              lfsr_ctl.step = 1'b1;
              oload         = 1'b1;
              ovalid_nxt    = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      byte_r   <= BYTE_0;
      count_r  <= '0;
      buf_r    <= '0;
      sync_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      byte_r   <= byte_nxt;
      count_r  <= count_nxt;
      buf_r    <= buf_nxt;
      sync_r   <= sync_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    d0_r   <= d0_nxt;
    d1_r   <= d1_nxt;
    if (oload) begin
      odur_r  <= d0_r;
      obri_r  <= d1_r;
      ooct_r  <= plain[7:4];
      onote_r <= plain[3:0];
      oend_r  <= (d0_r == 8'h00);
    end
  end

  assign out_valid      = ovalid_r;
  assign out_duration   = odur_r;
  assign out_brightness = obri_r;
  assign out_octave     = ooct_r;
  assign out_note       = onote_r;
  assign out_end_marker = oend_r;

  // the sync walk never runs with an exhausted step count
  a_sync_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SYNC |-> sync_r != '0)
    else $error("sync state with zero steps left");

  // a closing symbol starts descrambling at the first byte
  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_command == CMD_SYMBOL && count_r == 2'd3
    |=> state_r == ST_DESC && byte_r == BYTE_0)
    else $error("fourth symbol did not start descrambling");

  // end marker agrees with the registered duration
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> oend_r == (odur_r == 8'h00))
    else $error("end marker mismatch");

  // a pending result is never overwritten by the last descramble step
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ready |-> !oload)
    else $error("result overwritten before it was taken");

endmodule
